[design/i2c_ebm_pkg.sv]
// Shared types and constants for the I2C EEPROM byte master.
// Used by the register block, the bus core, the top level and the checker.
package i2c_ebm_pkg;

   localparam int ADDR_WIDTH_DEF = 16;
   localparam int CSR_IDX_W      = 2;
   localparam int CSR_DATA_W     = 16;

   // request codes
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_READ  = 2'd1;
   localparam logic [1:0] CMD_WRITE = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ADDR_MODE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_US  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WRITE_WAIT_US = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_TIMEOUT   = 2'd3;

   // register reset values
   localparam logic        RST_ADDR_MODE     = 1'b0;
   localparam logic [7:0]  RST_TICKS_PER_US  = 8'd48;
   localparam logic [15:0] RST_WRITE_WAIT_US = 16'd10000;
   localparam logic [7:0]  RST_ACK_TIMEOUT   = 8'd250;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [7:0]  device_base;
      logic [15:0] mem_addr;
      logic [7:0]  write_data;
      logic        sda_in;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_error;
   } rsp_type;

   typedef struct packed {
      logic        addr_mode;
      logic [7:0]  ticks_per_us;
      logic [15:0] write_wait_us;
      logic [7:0]  ack_timeout;
   } cfg_type;

endpackage

[design/i2c_eeprom_byte_master_unit.sv]
// Top level of the I2C EEPROM byte master: input register, bus core, result register.
// Depends on i2c_ebm_pkg, i2c_ebm_csr and i2c_ebm_core.
//
// Pin-level I2C master for one serial EEPROM byte read or byte write per request.
// Every transfer on the req_ channel is one bus tick: it carries the sampled SDA
// level and, while the master is idle, an optional read or write request. Every
// tick gives exactly one rsp_ transfer with the SCL/SDA drive levels and status
// (busy, done, ack_error, last read byte). One tick is taken per clock cycle
// when neither side stalls; a tick is held in the input register, runs through
// the core, and its result is loaded into the result register, from which the
// matching rsp_ transfer is made. The cycle is set by the
// per-tick phase logic of the core, whose longest path is the phase-length
// product of a microsecond count and ticks_per_us. Timing registers are to be
// written through csr_ only while the master is idle (the block does not enforce
// this) and take effect on the next tick. A slave ACK that stays high past
// ack_timeout ticks ends the transaction with a stop and ack_error on the done tick.
module i2c_eeprom_byte_master_unit #(
   parameter int ADDR_WIDTH = i2c_ebm_pkg::ADDR_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // tick input channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  i2c_ebm_pkg::req_type                req_data,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output i2c_ebm_pkg::rsp_type                rsp_data,
   // configuration writes
   input  logic                                csr_we,
   input  logic [i2c_ebm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [i2c_ebm_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import i2c_ebm_pkg::*;

   cfg_type cfg;

   logic    in_vld_ff,  in_vld_in;
   req_type in_data_ff, in_data_in;
   logic    out_vld_ff, out_vld_in;
   rsp_type out_data_ff, out_data_in;

   logic    out_free;   // result register can take a new result this cycle
   logic    step;       // the held tick runs through the core this cycle
   rsp_type core_rsp;

   i2c_ebm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   i2c_ebm_core #(
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step_en (step),
      .item    (in_data_ff),
      .cfg     (cfg),
      .result  (core_rsp)
   );

   assign out_free  = !out_vld_ff || !rsp_stall;
   assign step      = in_vld_ff && out_free;
   // input register is only blocked when its tick cannot move on
   assign req_stall = in_vld_ff && !out_free;

   always_comb begin
      in_vld_in   = in_vld_ff;
      in_data_in  = in_data_ff;
      out_vld_in  = out_vld_ff;
      out_data_in = out_data_ff;
      if (!req_stall) begin
         in_vld_in  = req_valid;
         in_data_in = req_data;
      end
      if (out_free) begin
         out_vld_in  = step;
         out_data_in = core_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

endmodule

[design/i2c_ebm_csr.sv]
// Configuration registers of the I2C EEPROM byte master.
// Depends on i2c_ebm_pkg.
module i2c_ebm_csr (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [i2c_ebm_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [i2c_ebm_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output i2c_ebm_pkg::cfg_type                    cfg
);
   import i2c_ebm_pkg::*;

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_ADDR_MODE:     cfg_in.addr_mode     = csr_wdata[0];
            CSR_TICKS_PER_US:  cfg_in.ticks_per_us  = csr_wdata[7:0];
            CSR_WRITE_WAIT_US: cfg_in.write_wait_us = csr_wdata;
            CSR_ACK_TIMEOUT:   cfg_in.ack_timeout   = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.addr_mode     <= RST_ADDR_MODE;
         cfg_ff.ticks_per_us  <= RST_TICKS_PER_US;
         cfg_ff.write_wait_us <= RST_WRITE_WAIT_US;
         cfg_ff.ack_timeout   <= RST_ACK_TIMEOUT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[design/i2c_ebm_core.sv]
// Bus phase sequencer: one call per tick, state held in flops, result combinational.
// Depends on i2c_ebm_pkg.
module i2c_ebm_core #(
   parameter int ADDR_WIDTH = i2c_ebm_pkg::ADDR_WIDTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step_en,
   input  i2c_ebm_pkg::req_type  item,
   input  i2c_ebm_pkg::cfg_type  cfg,
   output i2c_ebm_pkg::rsp_type  result
);
   import i2c_ebm_pkg::*;

   typedef enum logic [15:0] {
      PH_IDLE  = 16'h0001,
      PH_ST_A  = 16'h0002,
      PH_ST_B  = 16'h0004,
      PH_TX_A  = 16'h0008,
      PH_TX_B  = 16'h0010,
      PH_TX_C  = 16'h0020,
      PH_ACK_A = 16'h0040,
      PH_ACK_B = 16'h0080,
      PH_POLL  = 16'h0100,
      PH_RX_A  = 16'h0200,
      PH_RX_B  = 16'h0400,
      PH_NK_A  = 16'h0800,
      PH_NK_B  = 16'h1000,
      PH_SP_A  = 16'h2000,
      PH_SP_B  = 16'h4000,
      PH_WAIT  = 16'h8000
   } phase_type;

   // byte sequence steps
   localparam logic [2:0] STEP_DEV  = 3'd0;
   localparam logic [2:0] STEP_HIGH = 3'd1;
   localparam logic [2:0] STEP_LOW  = 3'd2;
   localparam logic [2:0] STEP_LAST = 3'd3;

   // phase length in ticks, never below one
   function automatic logic [23:0] delay_for(phase_type p, cfg_type c);
      logic [15:0] us;
      logic [23:0] t;
      case (p)
         PH_ST_A, PH_ST_B, PH_SP_A, PH_SP_B: us = 16'd4;
         PH_TX_A, PH_TX_B, PH_TX_C, PH_RX_A: us = 16'd12;
         PH_ACK_A, PH_ACK_B, PH_RX_B:        us = 16'd1;
         PH_NK_A, PH_NK_B:                   us = 16'd2;
         PH_WAIT:                            us = c.write_wait_us;
         default:                            us = 16'd0;
      endcase
      t = {8'd0, us} * {16'd0, c.ticks_per_us};
      return (t == 24'd0) ? 24'd1 : t;
   endfunction

   function automatic logic [7:0] byte_for(logic [2:0] stp, logic amode, logic [7:0] base,
                                            logic [15:0] addr, logic [7:0] data, logic wr);
      logic [7:0] b;
      case (stp)
         STEP_DEV:  b = amode ? base : base + {addr[14:8], 1'b0};
         STEP_HIGH: b = addr[15:8];
         STEP_LOW:  b = addr[7:0];
         default:   b = wr ? data : base + 8'd1;
      endcase
      return b;
   endfunction

   phase_type             phase_ff,    phase_in;
   logic [3:0]            bit_cnt_ff,  bit_cnt_in;
   logic [7:0]            shift_ff,    shift_in;
   logic [2:0]            bstep_ff,    bstep_in;
   logic [23:0]           delay_ff,    delay_in;
   logic [7:0]            tmo_ff,      tmo_in;
   logic                  hold_wr_ff,  hold_wr_in;
   logic [7:0]            hold_base_ff, hold_base_in;
   logic [ADDR_WIDTH-1:0] hold_addr_ff, hold_addr_in;
   logic [7:0]            hold_data_ff, hold_data_in;
   logic [7:0]            rd_ff,       rd_in;
   logic                  err_ff,      err_in;

   logic       scl, sda, busy, done, tick_end;
   logic       send_go, enter_go;
   logic [2:0] send_sel;
   phase_type  enter_ph;
   logic [15:0] addr16;

   always_comb begin
      phase_in     = phase_ff;
      bit_cnt_in   = bit_cnt_ff;
      shift_in     = shift_ff;
      bstep_in     = bstep_ff;
      delay_in     = delay_ff;
      tmo_in       = tmo_ff;
      hold_wr_in   = hold_wr_ff;
      hold_base_in = hold_base_ff;
      hold_addr_in = hold_addr_ff;
      hold_data_in = hold_data_ff;
      rd_in        = rd_ff;
      err_in       = err_ff;
      scl          = 1'b1;
      sda          = 1'b1;
      done         = 1'b0;
      tick_end     = 1'b0;
      send_go      = 1'b0;
      send_sel     = STEP_DEV;
      enter_go     = 1'b0;
      enter_ph     = PH_IDLE;

      // new request only when idle
      if (phase_ff == PH_IDLE && (item.cmd == CMD_READ || item.cmd == CMD_WRITE)) begin
         hold_wr_in   = (item.cmd == CMD_WRITE);
         hold_base_in = item.device_base;
         hold_addr_in = item.mem_addr[ADDR_WIDTH-1:0];
         hold_data_in = item.write_data;
         err_in       = 1'b0;
         bstep_in     = STEP_DEV;
         bit_cnt_in   = 4'd0;
         tmo_in       = 8'd0;
         phase_in     = PH_ST_A;
         delay_in     = delay_for(PH_ST_A, cfg);
      end

      // pin levels of the phase occupied this tick
      case (phase_in)
         PH_ST_B:                    sda = 1'b0;
         PH_TX_A, PH_TX_C: begin
            scl = 1'b0;
            sda = shift_ff[7];
         end
         PH_TX_B:                    sda = shift_ff[7];
         PH_ACK_A, PH_RX_A, PH_NK_A: scl = 1'b0;
         PH_SP_A: begin
            scl = 1'b0;
            sda = 1'b0;
         end
         default: begin
            scl = 1'b1;
            sda = 1'b1;
         end
      endcase
      busy = (phase_in != PH_IDLE);

      if (busy && phase_in != PH_POLL) begin
         if (delay_in > 24'd1) begin
            delay_in = delay_in - 24'd1;
         end else begin
            tick_end = 1'b1;
         end
      end

      addr16 = 16'(hold_addr_in);

      if (phase_in == PH_POLL) begin
         if (!item.sda_in) begin
            // slave acked: pick what follows this byte
            case (bstep_in)
               STEP_DEV: begin
                  send_go  = 1'b1;
                  send_sel = cfg.addr_mode ? STEP_HIGH : STEP_LOW;
               end
               STEP_HIGH: begin
                  send_go  = 1'b1;
                  send_sel = STEP_LOW;
               end
               STEP_LOW: begin
                  if (hold_wr_in) begin
                     send_go  = 1'b1;
                     send_sel = STEP_LAST;
                  end else begin
                     bstep_in = STEP_LAST;
                     enter_go = 1'b1;
                     enter_ph = PH_ST_A;
                  end
               end
               default: begin
                  if (hold_wr_in) begin
                     enter_go = 1'b1;
                     enter_ph = PH_SP_A;
                  end else begin
                     bit_cnt_in = 4'd0;
                     shift_in   = 8'd0;
                     enter_go   = 1'b1;
                     enter_ph   = PH_RX_A;
                  end
               end
            endcase
         end else if (tmo_in >= cfg.ack_timeout) begin
            err_in   = 1'b1;
            enter_go = 1'b1;
            enter_ph = PH_SP_A;
         end else begin
            tmo_in = tmo_in + 8'd1;
         end
      end else if (tick_end) begin
         case (phase_in)
            PH_ST_A: begin
               enter_go = 1'b1;
               enter_ph = PH_ST_B;
            end
            PH_ST_B: begin
               send_go  = 1'b1;
               send_sel = bstep_in;
            end
            PH_TX_A: begin
               enter_go = 1'b1;
               enter_ph = PH_TX_B;
            end
            PH_TX_B: begin
               enter_go = 1'b1;
               enter_ph = PH_TX_C;
            end
            PH_TX_C: begin
               bit_cnt_in = bit_cnt_in + 4'd1;
               enter_go   = 1'b1;
               if (bit_cnt_in < 4'd8) begin
                  shift_in = {shift_in[6:0], 1'b0};
                  enter_ph = PH_TX_A;
               end else begin
                  enter_ph = PH_ACK_A;
               end
            end
            PH_ACK_A: begin
               enter_go = 1'b1;
               enter_ph = PH_ACK_B;
            end
            PH_ACK_B: begin
               enter_go = 1'b1;
               enter_ph = PH_POLL;
            end
            PH_RX_A: begin
               enter_go = 1'b1;
               enter_ph = PH_RX_B;
            end
            PH_RX_B: begin
               shift_in   = {shift_in[6:0], item.sda_in};
               bit_cnt_in = bit_cnt_in + 4'd1;
               enter_go   = 1'b1;
               if (bit_cnt_in < 4'd8) begin
                  enter_ph = PH_RX_A;
               end else begin
                  rd_in    = shift_in;
                  enter_ph = PH_NK_A;
               end
            end
            PH_NK_A: begin
               enter_go = 1'b1;
               enter_ph = PH_NK_B;
            end
            PH_NK_B: begin
               enter_go = 1'b1;
               enter_ph = PH_SP_A;
            end
            PH_SP_A: begin
               enter_go = 1'b1;
               enter_ph = PH_SP_B;
            end
            PH_SP_B: begin
               if (!err_in && hold_wr_in) begin
                  enter_go = 1'b1;
                  enter_ph = PH_WAIT;
               end else begin
                  done     = 1'b1;
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               done     = 1'b1;
               phase_in = PH_IDLE;
            end
         endcase
      end

      if (send_go) begin
         bstep_in   = send_sel;
         shift_in   = byte_for(send_sel, cfg.addr_mode, hold_base_in, addr16,
                               hold_data_in, hold_wr_in);
         bit_cnt_in = 4'd0;
         enter_go   = 1'b1;
         enter_ph   = PH_TX_A;
      end

      if (enter_go) begin
         phase_in = enter_ph;
         delay_in = delay_for(enter_ph, cfg);
         if (enter_ph == PH_POLL) begin
            tmo_in = 8'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         bit_cnt_ff   <= '0;
         shift_ff     <= '0;
         bstep_ff     <= '0;
         delay_ff     <= '0;
         tmo_ff       <= '0;
         hold_wr_ff   <= 1'b0;
         hold_base_ff <= '0;
         hold_addr_ff <= '0;
         hold_data_ff <= '0;
         rd_ff        <= '0;
         err_ff       <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         bit_cnt_ff   <= bit_cnt_in;
         shift_ff     <= shift_in;
         bstep_ff     <= bstep_in;
         delay_ff     <= delay_in;
         tmo_ff       <= tmo_in;
         hold_wr_ff   <= hold_wr_in;
         hold_base_ff <= hold_base_in;
         hold_addr_ff <= hold_addr_in;
         hold_data_ff <= hold_data_in;
         rd_ff        <= rd_in;
         err_ff       <= err_in;
      end
   end

   always_comb begin
      result.scl_level = scl;
      result.sda_level = sda;
      result.busy_res  = busy;
      result.done_res  = done;
      result.read_byte = rd_in;
      result.ack_error = done & err_in;
   end

endmodule

[design/i2c_ebm_checker.sv]
// Port-level checks for the I2C EEPROM byte master, bound to the top level.
// Depends on i2c_ebm_pkg and i2c_eeprom_byte_master_unit.
module i2c_ebm_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input i2c_ebm_pkg::rsp_type                rsp_data
);
   import i2c_ebm_pkg::*;

   // a result register that is cleared by reset shows nothing the cycle after
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // a transaction end is always inside a busy stretch
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.done_res |-> rsp_data.busy_res)
      else $error("done without busy");

   // error only reported with done
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.ack_error |-> rsp_data.done_res)
      else $error("ack_error outside done tick");

   // idle bus leaves both lines released
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.busy_res |-> rsp_data.scl_level && rsp_data.sda_level)
      else $error("lines driven low while idle");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind i2c_eeprom_byte_master_unit i2c_ebm_checker u_ebm_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
